// File: rtl/r4inv_pkg.sv
// Shared types, moduli and command encodings for the radix-4 modular inverse core.
package r4inv_pkg;

  localparam int unsigned LimbCount = 4;
  localparam int unsigned WordW     = 64 * LimbCount;

  localparam logic [WordW-1:0] ModP =
    256'hfffffffeffffffff_ffffffffffffffff_ffffffff00000000_ffffffffffffffff;
  localparam logic [WordW-1:0] ModN =
    256'hfffffffeffffffff_ffffffffffffffff_7203df6b21c6052b_53bbf40939d54123;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_HALF_U,
    CMD_HALF_V,
    CMD_SUB_U,
    CMD_SUB_V
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] u_low;
    logic [1:0] v_low;
    logic       u_one;
    logic       v_one;
    logic       u_gt_v;
    logic       bad_operand;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DECIDE,
    ST_HALF,
    ST_SUB,
    ST_DONE
  } ctrl_state_t;

endpackage

// File: rtl/r4inv_datapath.sv
// Datapath: remainders u, v and coefficients x1, x2 with one halving or subtraction per cycle, as commanded.
module r4inv_datapath (
  input  logic                 clk,
  input  logic                 sel_load,
  input  r4inv_pkg::dp_cmd_t   cmd,
  input  logic                 op,
  input  logic [63:0]          in_w0,
  input  logic [63:0]          in_w1,
  input  logic [63:0]          in_w2,
  input  logic [63:0]          in_w3,
  output r4inv_pkg::dp_status_t sts,
  output logic [255:0]         result
);
  import r4inv_pkg::*;

  logic [WordW-1:0] u, v, x1, x2, m;
  logic             mod_sel;
  logic [WordW-1:0] operand, mod_in;
  logic [WordW:0]   diff_uv, diff_x, half_src;
  logic [WordW-1:0] sub_x;
  logic             x_sel;

  assign operand = {in_w3, in_w2, in_w1, in_w0};
  assign mod_in  = op ? ModN : ModP;
  assign m       = mod_sel ? ModN : ModP;

  // Status for the controller
  assign sts.u_low       = u[1:0];
  assign sts.v_low       = v[1:0];
  assign sts.u_one       = (u == WordW'(1));
  assign sts.v_one       = (v == WordW'(1));
  assign sts.u_gt_v      = (u > v);
  assign sts.bad_operand = (operand == '0) || (operand >= mod_in);

  // Subtraction of the smaller remainder and its coefficient
  assign x_sel   = (cmd == CMD_SUB_U);
  assign diff_uv = x_sel ? ({1'b0, u} - {1'b0, v}) : ({1'b0, v} - {1'b0, u});
  assign diff_x  = x_sel ? ({1'b0, x1} - {1'b0, x2}) : ({1'b0, x2} - {1'b0, x1});
  assign sub_x   = diff_x[WordW] ? (diff_x[WordW-1:0] + m) : diff_x[WordW-1:0];

  // Modular halving source
  always_comb begin
    if (cmd == CMD_HALF_U) begin
      half_src = x1[0] ? ({1'b0, x1} + {1'b0, m}) : {1'b0, x1};
    end else begin
      half_src = x2[0] ? ({1'b0, x2} + {1'b0, m}) : {1'b0, x2};
    end
  end

  // Advance the registers by the command
  always_ff @(posedge clk) begin
    if (sel_load) begin
      mod_sel <= op;
    end
    case (cmd)
      CMD_LOAD: begin
        u  <= operand;
        v  <= mod_in;
        x1 <= WordW'(1);
        x2 <= '0;
      end
      CMD_HALF_U: begin
        u  <= u >> 1;
        x1 <= half_src[WordW:1];
      end
      CMD_HALF_V: begin
        v  <= v >> 1;
        x2 <= half_src[WordW:1];
      end
      CMD_SUB_U: begin
        u  <= diff_uv[WordW-1:0];
        x1 <= sub_x;
      end
      CMD_SUB_V: begin
        v  <= diff_uv[WordW-1:0];
        x2 <= sub_x;
      end
      default: begin
      end
    endcase
  end

  assign result = sts.u_one ? x1 : x2;
endmodule

// File: rtl/r4inv_ctrl.sv
// Controller state machine sequencing the binary Euclid steps.
module r4inv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  r4inv_pkg::dp_status_t sts,
  output r4inv_pkg::dp_cmd_t    cmd,
  output logic                  sel_load,
  output logic                  err
);
  import r4inv_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  halves, halves_next;
  logic        on_u, on_u_next;
  logic        err_next;

  // Hold state and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      halves <= '0;
      on_u   <= 1'b0;
      err    <= 1'b0;
    end else begin
      state  <= state_next;
      halves <= halves_next;
      on_u   <= on_u_next;
      err    <= err_next;
    end
  end

  // Choose the next step from the state, the operand check and the low bits of u and v
  always_comb begin
    state_next  = state;
    halves_next = halves;
    on_u_next   = on_u;
    err_next    = err;
    cmd         = CMD_IDLE;
    sel_load    = 1'b0;
    in_stall    = (state != ST_IDLE);
    out_valid   = (state == ST_DONE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sel_load = 1'b1;
          if (sts.bad_operand) begin
            err_next   = 1'b1;
            state_next = ST_DONE;
          end else begin
            err_next   = 1'b0;
            cmd        = CMD_LOAD;
            state_next = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (sts.u_one || sts.v_one) begin
          state_next = ST_DONE;
        end else if (sts.u_low == 2'd0) begin
          cmd = CMD_HALF_U; halves_next = 2'd1; on_u_next = 1'b1; state_next = ST_HALF;
        end else if (sts.v_low == 2'd0) begin
          cmd = CMD_HALF_V; halves_next = 2'd1; on_u_next = 1'b0; state_next = ST_HALF;
        end else if (sts.u_low == sts.v_low) begin
          halves_next = 2'd2; state_next = ST_SUB;
        end else if (sts.u_low == 2'd2) begin
          cmd = CMD_HALF_U; halves_next = 2'd1; state_next = ST_SUB;
        end else if (sts.v_low == 2'd2) begin
          cmd = CMD_HALF_V; halves_next = 2'd1; state_next = ST_SUB;
        end else begin
          halves_next = 2'd1; state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        on_u_next  = sts.u_gt_v;
        cmd        = sts.u_gt_v ? CMD_SUB_U : CMD_SUB_V;
        state_next = ST_HALF;
      end
      ST_HALF: begin
        if (halves == 2'd0) begin
          state_next = ST_DECIDE;
        end else begin
          cmd         = on_u ? CMD_HALF_U : CMD_HALF_V;
          halves_next = halves - 2'd1;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (cmd == CMD_IDLE)) else $error("command issued while done");
  a_halves_range: assert property (@(posedge clk) disable iff (rst)
    halves != 2'd3) else $error("halving count out of range");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_stall) |=> (state == ST_DONE)) else $error("result dropped");
`endif
endmodule

// File: rtl/radix4_binary_modular_inverse_core.sv
// A zero or out-of-range operand is answered in the cycle after its transfer; a valid
// operand is worked through Euclid passes of decide, subtract and halving steps until u
// or v reaches one, all on the single shared halving/subtract datapath.
// Throughput: one item at a time; the next transfer is taken once the result has gone.
// Reset: rst (synchronous, active high) clears the controller to idle with no result held.
// The remainder and coefficient registers are not reset.
module radix4_binary_modular_inverse_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [63:0] in_w0,
  input  logic [63:0] in_w1,
  input  logic [63:0] in_w2,
  input  logic [63:0] in_w3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_w0,
  output logic [63:0] out_w1,
  output logic [63:0] out_w2,
  output logic [63:0] out_w3,
  output logic        status
);
  import r4inv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic       sel_load, err;
  logic [WordW-1:0] result;

  r4inv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .sel_load(sel_load), .err(err)
  );

  r4inv_datapath u_dp (
    .clk(clk), .sel_load(sel_load), .cmd(cmd), .op(op),
    .in_w0(in_w0), .in_w1(in_w1), .in_w2(in_w2), .in_w3(in_w3),
    .sts(sts), .result(result)
  );

  // Drive zero on error
  assign out_w0 = err ? 64'd0 : result[63:0];
  assign out_w1 = err ? 64'd0 : result[127:64];
  assign out_w2 = err ? 64'd0 : result[191:128];
  assign out_w3 = err ? 64'd0 : result[255:192];
  assign status = err;
endmodule

// File: test/radix4_binary_modular_inverse_core_checker.sv
// Channel monitor, modular inverse predictor and result comparison for the inverse core.
`timescale 1ns / 100ps

module radix4_binary_modular_inverse_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        op,
  input  logic [63:0] in_w0,
  input  logic [63:0] in_w1,
  input  logic [63:0] in_w2,
  input  logic [63:0] in_w3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_w0,
  input  logic [63:0] out_w1,
  input  logic [63:0] out_w2,
  input  logic [63:0] out_w3,
  input  logic        status,
  output int          fail_count,
  output int          pending
);
  import r4inv_pkg::*;

  typedef struct packed {
    logic [255:0] inverse;
    logic         bad;
  } inv_result_t;

  inv_result_t expected_inverses[$];

  // Halve x modulo odd m, keeping the carry of x + m
  function automatic logic [255:0] half_mod(logic [255:0] x, logic [255:0] m);
    logic [256:0] s;
    s = x[0] ? ({1'b0, x} + {1'b0, m}) : {1'b0, x};
    return s[256:1];
  endfunction

  function automatic logic [255:0] sub_mod(logic [255:0] x, logic [255:0] y,
                                          logic [255:0] m);
    logic [255:0] d;
    d = x - y;
    if (x < y) d = d + m;
    return d;
  endfunction

  // Radix-4 binary extended Euclid inverse
  function automatic inv_result_t predict_inverse(logic sel, logic [255:0] a);
    logic [255:0] m, u, v, x1, x2;
    logic [1:0]   c, d;
    inv_result_t  r;
    m = sel ? ModN : ModP;
    r.inverse = '0;
    r.bad = 1'b1;
    if (a == 0 || a >= m) return r;
    u = a; v = m; x1 = 256'd1; x2 = '0;
    while (u != 1 && v != 1) begin
      c = u[1:0];
      d = v[1:0];
      if (c == 0) begin
        u = u >> 2; x1 = half_mod(half_mod(x1, m), m);
      end else if (d == 0) begin
        v = v >> 2; x2 = half_mod(half_mod(x2, m), m);
      end else begin
        int k;
        k = (c == d) ? 2 : 1;
        if (c == 2 && d != c) begin
          u = u >> 1; x1 = half_mod(x1, m);
        end else if (d == 2 && d != c) begin
          v = v >> 1; x2 = half_mod(x2, m);
        end
        if (u > v) begin
          u = u - v; x1 = sub_mod(x1, x2, m);
          repeat (k) begin u = u >> 1; x1 = half_mod(x1, m); end
        end else begin
          v = v - u; x2 = sub_mod(x2, x1, m);
          repeat (k) begin v = v >> 1; x2 = half_mod(x2, m); end
        end
      end
    end
    r.inverse = (u == 1) ? x1 : x2;
    r.bad = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    inv_result_t want;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_inverses.push_back(predict_inverse(op, {in_w3, in_w2, in_w1, in_w0}));
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected result", {out_w3, out_w2, out_w1, out_w0}, '0);
        end else begin
          want = expected_inverses.pop_front();
          if (out_w0 !== want.inverse[63:0])
            report_mismatch("out_w0", out_w0, want.inverse[63:0]);
          if (out_w1 !== want.inverse[127:64])
            report_mismatch("out_w1", out_w1, want.inverse[127:64]);
          if (out_w2 !== want.inverse[191:128])
            report_mismatch("out_w2", out_w2, want.inverse[191:128]);
          if (out_w3 !== want.inverse[255:192])
            report_mismatch("out_w3", out_w3, want.inverse[255:192]);
          if (status !== want.bad)
            report_mismatch("status", status, want.bad);
        end
      end
    end
    pending = expected_inverses.size();
  end

endmodule

// File: test/radix4_binary_modular_inverse_core_tb.sv
// Stimulus, clock, reset and verdict for the radix-4 modular inverse core.
`timescale 1ns / 100ps

module radix4_binary_modular_inverse_core_tb;
  import r4inv_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [63:0] in_w0 = '0, in_w1 = '0, in_w2 = '0, in_w3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_w0, out_w1, out_w2, out_w3;
  logic        status;
  int          fail_count;
  int          pending;
  bit          hold_off_long = 1'b0;

  always #2 clk = ~clk;

  radix4_binary_modular_inverse_core uut (.*);

  radix4_binary_modular_inverse_core_checker checker_i (.*);

  function automatic logic [255:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Drive one transfer after a random gap
  task automatic send_operand(logic sel, logic [255:0] a);
    repeat ($urandom_range(0, 7)) @(negedge clk);
    op <= sel;
    {in_w3, in_w2, in_w1, in_w0} <= a;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Receiver: random stall per result, with one long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_long) begin
        out_stall <= 1'b1;
        repeat (6000) @(negedge clk);
        hold_off_long = 1'b0;
      end
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Hard limit on run length
  initial begin
    #40ms;
    $display("radix4_binary_modular_inverse_core: mismatch");
    $finish;
  end

  initial begin
    logic [255:0] m, a;
    logic         sel;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero, one, two, three, m-1, m, m+1, all ones, m/2, top bit, ModP ^ ModN, both moduli
    for (int s = 0; s < 2; s++) begin
      m = s ? ModN : ModP;
      send_operand(s[0], '0);
      send_operand(s[0], 256'd1);
      send_operand(s[0], 256'd2);
      send_operand(s[0], 256'd3);
      send_operand(s[0], m - 256'd1);
      send_operand(s[0], m);
      send_operand(s[0], m + 256'd1);
      send_operand(s[0], '1);
      send_operand(s[0], m >> 1);
      send_operand(s[0], 256'd1 << 255);
      send_operand(s[0], ModP ^ ModN);
    end

    // Let results drain, then fill the block while the receiver holds off
    while (pending != 0) @(negedge clk);
    hold_off_long = 1'b1;
    for (int i = 0; i < 4; i++) send_operand(i[0], rand_wide() >> 8);

    // Random: mostly valid operands, some zero or out of range
    for (int i = 0; i < 740; i++) begin
      sel = 1'($urandom_range(0, 1));
      m = sel ? ModN : ModP;
      case ($urandom_range(0, 9))
        0: a = rand_wide();
        1: a = rand_wide() >> $urandom_range(0, 255);
        2: a = m - 256'($urandom_range(0, 3));
        default: begin
          a = rand_wide();
          if (a >= m) a = a - m;
        end
      endcase
      send_operand(sel, a);
    end

    while (pending != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
    if (fail_count == 0) begin
      $display("radix4_binary_modular_inverse_core: match");
    end else begin
      $display("radix4_binary_modular_inverse_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/r4inv_pkg.sv
rtl/r4inv_datapath.sv
rtl/r4inv_ctrl.sv
rtl/radix4_binary_modular_inverse_core.sv
test/radix4_binary_modular_inverse_core_checker.sv
test/radix4_binary_modular_inverse_core_tb.sv
